FILE: hdl/gbs_pkg.sv
// ----------------------------------------------------------------------------
// Greedy box suppression package
// Shared sizes, limits and the layout of one kept-list entry.
// ----------------------------------------------------------------------------
package gbs_pkg;

    localparam int MAX_KEPT  = 64;
    localparam int CNT_W     = $clog2(MAX_KEPT + 1);
    localparam int IDX_W     = $clog2(MAX_KEPT);
    localparam int COORD_W   = 16;
    localparam int EDGE_W    = COORD_W + 1;
    localparam int SIZE_W    = 15;
    localparam int AREA_W    = 2 * SIZE_W;
    localparam int UNION_W   = AREA_W + 1;
    localparam int THR_W     = 16;
    localparam int PROD_W    = THR_W + UNION_W;
    localparam int SLOT_W    = 6;

    localparam logic [THR_W-1:0] IOU_RESET = 16'd45875;

    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
        logic [AREA_W-1:0]        area;
    } kept_entry_t;

endpackage

FILE: hdl/gbs_box_if.sv
// ----------------------------------------------------------------------------
// Box channel
// Valid/ready channel that carries one candidate box per word.
// ----------------------------------------------------------------------------
interface gbs_box_if import gbs_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic                      frame_start;
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic [SIZE_W-1:0]         box_width;
    logic [SIZE_W-1:0]         box_height;

    modport source (output valid, frame_start, box_left, box_top, box_width, box_height,
                    input ready);
    modport sink   (input valid, frame_start, box_left, box_top, box_width, box_height,
                    output ready);

endinterface

FILE: hdl/gbs_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one suppression decision per word.
// ----------------------------------------------------------------------------
interface gbs_result_if import gbs_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              keep;
    logic [SLOT_W-1:0] kept_slot;
    logic              list_overflow;

    modport source (output valid, keep, kept_slot, list_overflow, input ready);
    modport sink   (input valid, keep, kept_slot, list_overflow, output ready);

endinterface

FILE: hdl/greedy_box_suppression_top.sv
// ----------------------------------------------------------------------------
// Greedy box suppression
// Greedy non-maximum suppression by intersection over union for score-sorted
// boxes.
//
// Boxes enter on the boxes channel, one word per box, already sorted by
// falling score. A word with frame_start set empties the kept list first.
// Each box is compared with every kept box of the frame; one result word per
// box leaves on the results channel with keep, kept_slot and list_overflow.
// The kept list sits in one memory with a registered read port, read one
// entry per cycle into the compare pipeline. One box is in work at a time;
// the next box is accepted as soon as the previous result is loaded into
// the output register, even while that result still waits.
// When the receiver stalls, the finished result waits in its register and
// the following box finishes its scan, then holds until the register frees.
// Reset empties the kept list and sets iou_threshold to 45875 (about 0.7).
// The threshold is written through cfg_wr_en and cfg_wr_data. The user must
// write it only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module greedy_box_suppression_top import gbs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [THR_W-1:0]   cfg_wr_data,
    gbs_box_if.sink            boxes,
    gbs_result_if.source       results
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam int PIPE_N = 5;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic               suppress_reg, suppress_next;
    logic [PIPE_N-1:0]  pipe_v_reg, pipe_v_next;
    logic [THR_W-1:0]   thr_reg, thr_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_keep_reg, out_keep_next;
    logic [SLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic               out_ovf_reg, out_ovf_next;

    logic signed [EDGE_W-1:0] cur_left_reg, cur_top_reg, cur_right_reg, cur_bottom_reg;
    logic [SIZE_W-1:0]        cur_w_reg, cur_h_reg;
    logic [AREA_W-1:0]        cur_area_reg;

    kept_entry_t        mem [MAX_KEPT];
    kept_entry_t        rd_data_reg;
    kept_entry_t        wr_entry;
    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   wr_addr;

    logic [SIZE_W-1:0]  dx_reg, dy_reg;
    logic [AREA_W-1:0]  ka1_reg, ka2_reg;
    logic [AREA_W-1:0]  inter2_reg, inter3_reg, inter4_reg;
    logic [UNION_W-1:0] uni3_reg;
    logic               uni_nz4_reg;
    logic [PROD_W-1:0]  prod4_reg;

    logic                     in_accept, out_free, hit;
    logic                     no_overlap;
    logic signed [EDGE_W-1:0] x0, x1, y0, y1, dx_full, dy_full;

    assign in_accept     = boxes.valid && boxes.ready;
    assign out_free      = !out_valid_reg || results.ready;
    assign boxes.ready   = (state_reg == ST_IDLE);
    assign results.valid         = out_valid_reg;
    assign results.keep          = out_keep_reg;
    assign results.kept_slot     = out_slot_reg;
    assign results.list_overflow = out_ovf_reg;

    assign rd_en = (state_reg == ST_SCAN) && (idx_reg < count_reg);

    // Kept-list memory with a registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Current box and area.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cur_left_reg   <= EDGE_W'(boxes.box_left);
            cur_top_reg    <= EDGE_W'(boxes.box_top);
            cur_right_reg  <= EDGE_W'(boxes.box_left) + $signed({2'b00, boxes.box_width});
            cur_bottom_reg <= EDGE_W'(boxes.box_top) + $signed({2'b00, boxes.box_height});
            cur_w_reg      <= boxes.box_width;
            cur_h_reg      <= boxes.box_height;
        end
        cur_area_reg <= cur_w_reg * cur_h_reg;
    end

    // Overlap extents against the entry just read.
    always_comb
    begin
        no_overlap = (cur_left_reg > rd_data_reg.right) || (cur_right_reg < rd_data_reg.left) ||
                     (cur_top_reg > rd_data_reg.bottom) || (cur_bottom_reg < rd_data_reg.top);
        x0 = (cur_left_reg > rd_data_reg.left) ? cur_left_reg : rd_data_reg.left;
        x1 = (cur_right_reg < rd_data_reg.right) ? cur_right_reg : rd_data_reg.right;
        y0 = (cur_top_reg > rd_data_reg.top) ? cur_top_reg : rd_data_reg.top;
        y1 = (cur_bottom_reg < rd_data_reg.bottom) ? cur_bottom_reg : rd_data_reg.bottom;
        dx_full = x1 - x0;
        dy_full = y1 - y0;
    end

    // Compare pipeline: extents, intersection, union, scaled union.
    always_ff @(posedge clk)
    begin
        dx_reg      <= no_overlap ? '0 : dx_full[SIZE_W-1:0];
        dy_reg      <= no_overlap ? '0 : dy_full[SIZE_W-1:0];
        ka1_reg     <= rd_data_reg.area;
        inter2_reg  <= dx_reg * dy_reg;
        ka2_reg     <= ka1_reg;
        uni3_reg    <= {1'b0, cur_area_reg} + {1'b0, ka2_reg} - {1'b0, inter2_reg};
        inter3_reg  <= inter2_reg;
        prod4_reg   <= thr_reg * uni3_reg;
        uni_nz4_reg <= (uni3_reg != '0);
        inter4_reg  <= inter3_reg;
    end

    assign hit = uni_nz4_reg && ({1'b0, inter4_reg, 16'b0} > prod4_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        suppress_next  = suppress_reg;
        pipe_v_next    = {pipe_v_reg[PIPE_N-2:0], rd_en};
        thr_next       = cfg_wr_en ? cfg_wr_data : thr_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_keep_next  = out_keep_reg;
        out_slot_next  = out_slot_reg;
        out_ovf_next   = out_ovf_reg;
        wr_en          = 1'b0;
        wr_addr        = count_reg[IDX_W-1:0];
        wr_entry       = '{left: cur_left_reg, top: cur_top_reg, right: cur_right_reg,
                           bottom: cur_bottom_reg, area: cur_area_reg};

        if (pipe_v_reg[PIPE_N-1] && hit)
        begin
            suppress_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (boxes.frame_start)
                    begin
                        count_next = '0;
                    end
                    idx_next      = '0;
                    suppress_next = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_v_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_keep_next  = 1'b0;
                    out_slot_next  = '0;
                    out_ovf_next   = 1'b0;
                    if (!suppress_reg)
                    begin
                        if (count_reg < CNT_W'(MAX_KEPT))
                        begin
                            wr_en         = 1'b1;
                            out_keep_next = 1'b1;
                            out_slot_next = SLOT_W'(count_reg);
                            count_next    = count_reg + 1'b1;
                        end
                        else
                        begin
                            out_ovf_next = 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            suppress_reg  <= 1'b0;
            pipe_v_reg    <= '0;
            thr_reg       <= IOU_RESET;
            out_valid_reg <= 1'b0;
            out_keep_reg  <= 1'b0;
            out_slot_reg  <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            suppress_reg  <= suppress_next;
            pipe_v_reg    <= pipe_v_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
            out_keep_reg  <= out_keep_next;
            out_slot_reg  <= out_slot_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

endmodule

FILE: hdl/gbs_checker.sv
// ----------------------------------------------------------------------------
// Greedy box suppression checker
// Port-level assertions on the box and result channels.
// ----------------------------------------------------------------------------
module gbs_checker import gbs_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_keep,
    input logic [SLOT_W-1:0] out_slot,
    input logic              out_ovf
);

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_keep) &&
        $stable(out_slot) && $stable(out_ovf))
        else $error("result word changed while stalled");

    // A kept box is never also reported as an overflow.
    a_keep_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_keep |-> !out_ovf)
        else $error("keep and list_overflow both set");

    // A box that is not kept reports slot zero.
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_keep |-> out_slot == '0)
        else $error("nonzero slot on a dropped box");

    // The block works on one box at a time.
    a_one_box: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second box accepted during a scan");

endmodule

bind greedy_box_suppression_top gbs_checker u_gbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (boxes.valid),
    .in_ready  (boxes.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_keep  (results.keep),
    .out_slot  (results.kept_slot),
    .out_ovf   (results.list_overflow)
);

FILE: tb/gbs_decision_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Suppression decision checker
// Watches the box and result channels and keeps its own kept list and
// threshold. It works out the decision for every accepted box and compares
// each result word with the oldest decision still waiting.
// ----------------------------------------------------------------------------
module gbs_decision_checker import gbs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [THR_W-1:0] cfg_wr_data,
    gbs_box_if               boxes,
    gbs_result_if            results,
    output int               mismatches,
    output int               pending
);

    typedef struct packed {
        logic signed [EDGE_W-1:0] left;
        logic signed [EDGE_W-1:0] top;
        logic signed [EDGE_W-1:0] right;
        logic signed [EDGE_W-1:0] bottom;
    } rect_t;

    typedef struct packed {
        logic              keep;
        logic [SLOT_W-1:0] slot;
        logic              overflow;
    } decision_t;

    rect_t             kept_rect [MAX_KEPT];
    logic [AREA_W-1:0] kept_area [MAX_KEPT];
    int                kept_total;
    logic [THR_W-1:0]  iou_limit;
    decision_t         decision_q [$];
    decision_t         want;
    int                fail_total = 0;
    int                waiting = 0;
    int                result_no = 0;

    assign mismatches = fail_total;
    assign pending    = waiting;

    function automatic logic [AREA_W-1:0] overlap_area(rect_t a, rect_t b);
        logic signed [EDGE_W-1:0] x0;
        logic signed [EDGE_W-1:0] x1;
        logic signed [EDGE_W-1:0] y0;
        logic signed [EDGE_W-1:0] y1;
        logic [SIZE_W-1:0]        dx;
        logic [SIZE_W-1:0]        dy;
        if (a.left > b.right || a.right < b.left || a.top > b.bottom || a.bottom < b.top)
            return '0;
        x0 = (a.left > b.left) ? a.left : b.left;
        x1 = (a.right < b.right) ? a.right : b.right;
        y0 = (a.top > b.top) ? a.top : b.top;
        y1 = (a.bottom < b.bottom) ? a.bottom : b.bottom;
        dx = SIZE_W'(x1 - x0);
        dy = SIZE_W'(y1 - y0);
        return AREA_W'(dx) * AREA_W'(dy);
    endfunction

    function automatic decision_t decide_box(logic fs, logic signed [COORD_W-1:0] l,
                                             logic signed [COORD_W-1:0] t,
                                             logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        rect_t              cur;
        logic [AREA_W-1:0]  cur_area;
        logic [AREA_W-1:0]  ov;
        logic [UNION_W-1:0] uni;
        logic [PROD_W-1:0]  scaled_ov;
        logic [PROD_W-1:0]  scaled_uni;
        logic               survive;
        decision_t          d;
        if (fs)
            kept_total = 0;
        cur.left   = l;
        cur.top    = t;
        cur.right  = cur.left + EDGE_W'(w);
        cur.bottom = cur.top + EDGE_W'(h);
        cur_area   = AREA_W'(w) * AREA_W'(h);
        survive    = 1'b1;
        for (int i = 0; i < kept_total; i++)
        begin
            ov         = overlap_area(cur, kept_rect[i]);
            uni        = UNION_W'(cur_area) + UNION_W'(kept_area[i]) - UNION_W'(ov);
            scaled_ov  = PROD_W'(ov) << THR_W;
            scaled_uni = PROD_W'(iou_limit) * PROD_W'(uni);
            if (uni != '0 && scaled_ov > scaled_uni)
                survive = 1'b0;
        end
        d = '0;
        if (survive)
        begin
            if (kept_total < MAX_KEPT)
            begin
                kept_rect[kept_total] = cur;
                kept_area[kept_total] = cur_area;
                d.keep = 1'b1;
                d.slot = SLOT_W'(kept_total);
                kept_total++;
            end
            else
            begin
                d.overflow = 1'b1;
            end
        end
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        fail_total++;
        $display("%0t: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_total = 0;
            iou_limit  = IOU_RESET;
            decision_q.delete();
            waiting = 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                if (decision_q.size() == 0)
                begin
                    report_mismatch($sformatf("result word %0d arrived with no box waiting",
                                              result_no));
                end
                else
                begin
                    want = decision_q.pop_front();
                    if (results.keep !== want.keep || results.kept_slot !== want.slot
                        || results.list_overflow !== want.overflow)
                        report_mismatch($sformatf(
                            "result word %0d: keep %b slot %0d overflow %b, expected %b %0d %b",
                            result_no, results.keep, results.kept_slot, results.list_overflow,
                            want.keep, want.slot, want.overflow));
                end
                result_no++;
            end
            if (cfg_wr_en)
                iou_limit = cfg_wr_data;
            if (boxes.valid && boxes.ready)
                decision_q.insert(decision_q.size(),
                                  decide_box(boxes.frame_start, boxes.box_left,
                                             boxes.box_top, boxes.box_width,
                                             boxes.box_height));
            waiting = decision_q.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy box suppression testbench
// Sends directed boxes for the edge cases, then frames of random boxes
// (clustered, jittered, disjoint grids that fill the kept list, and wild
// values) under several thresholds, with random gaps and stalls on both
// channels. The checker module predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

    import gbs_pkg::*;

    localparam int HALF_PERIOD = 5;
    localparam int RUN_LIMIT   = 1_000_000;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 205;

    typedef struct {
        logic signed [COORD_W-1:0] left;
        logic signed [COORD_W-1:0] top;
        logic [SIZE_W-1:0]         width;
        logic [SIZE_W-1:0]         height;
    } cand_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [THR_W-1:0] cfg_wr_data = '0;
    int               mismatches;
    int               pending;
    int               cycles = 0;
    int               sent = 0;
    int               stall_left = 0;
    bit               src_gaps = 1'b0;
    bit               sink_stalls = 1'b0;
    cand_t            frame_log [$];

    gbs_box_if    boxes ();
    gbs_result_if results ();

    greedy_box_suppression_top uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .boxes       (boxes),
        .results     (results)
    );

    gbs_decision_checker suppression_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .boxes       (boxes),
        .results     (results),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                results.ready <= 1'b0;
            end
            else if (sink_stalls && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    task automatic send_box(logic fs, cand_t b);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            boxes.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        boxes.valid       <= 1'b1;
        boxes.frame_start <= fs;
        boxes.box_left    <= b.left;
        boxes.box_top     <= b.top;
        boxes.box_width   <= b.width;
        boxes.box_height  <= b.height;
        @(posedge clk);
        while (!boxes.ready)
            @(posedge clk);
        @(negedge clk);
        frame_log.insert(frame_log.size(), b);
        sent++;
    endtask

    task automatic send_rect(logic fs, int l, int t, int w, int h);
        cand_t b;
        b.left   = COORD_W'(l);
        b.top    = COORD_W'(t);
        b.width  = SIZE_W'(w);
        b.height = SIZE_W'(h);
        send_box(fs, b);
    endtask

    task automatic drain();
        boxes.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic int clamp_size(int v);
        if (v < 0)
            return 0;
        if (v > 32767)
            return 32767;
        return v;
    endfunction

    function automatic cand_t nudge(cand_t b);
        cand_t n;
        n.left   = b.left + COORD_W'($urandom_range(0, 16) - 8);
        n.top    = b.top + COORD_W'($urandom_range(0, 16) - 8);
        n.width  = SIZE_W'(clamp_size(int'(b.width) + int'($urandom_range(0, 16)) - 8));
        n.height = SIZE_W'(clamp_size(int'(b.height) + int'($urandom_range(0, 16)) - 8));
        return n;
    endfunction

    task automatic run_frame(bit quiet);
        int                        style;
        int                        len;
        cand_t                     b;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        style = $urandom_range(0, 9);
        len   = (style == 0) ? $urandom_range(64, 70) : $urandom_range(1, 40);
        cx    = COORD_W'($urandom);
        cy    = COORD_W'($urandom);
        src_gaps    = !quiet && $urandom_range(0, 3) != 0;
        sink_stalls = !quiet && $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 7) == 0)
            drain();
        frame_log.delete();
        for (int k = 0; k < len; k++)
        begin
            if (style == 0)
            begin
                b.left   = cx + COORD_W'((k % 8) * 64);
                b.top    = cy + COORD_W'((k / 8) * 64);
                b.width  = SIZE_W'($urandom_range(0, 64));
                b.height = SIZE_W'($urandom_range(0, 64));
            end
            else if (style == 9)
            begin
                b.left   = COORD_W'($urandom);
                b.top    = COORD_W'($urandom);
                b.width  = SIZE_W'($urandom);
                b.height = SIZE_W'($urandom);
            end
            else if (k > 0 && $urandom_range(0, 2) == 0)
            begin
                b = nudge(frame_log[$urandom_range(0, frame_log.size() - 1)]);
            end
            else
            begin
                b.left   = cx + COORD_W'($urandom_range(0, 200) - 100);
                b.top    = cy + COORD_W'($urandom_range(0, 200) - 100);
                b.width  = SIZE_W'($urandom_range(1, 200));
                b.height = SIZE_W'($urandom_range(1, 200));
                if (style == 8 && $urandom_range(0, 1) == 0)
                    b.width = '0;
                if (style == 8 && $urandom_range(0, 1) == 0)
                    b.height = '0;
            end
            send_box(k == 0, b);
        end
    endtask

    initial
    begin
        logic [THR_W-1:0] limits [PHASE_COUNT];
        int               phase_start;
        boxes.valid       = 1'b0;
        boxes.frame_start = 1'b0;
        boxes.box_left    = '0;
        boxes.box_top     = '0;
        boxes.box_width   = '0;
        boxes.box_height  = '0;
        limits = '{IOU_RESET, 16'd0, 16'hFFFF, 16'd32768, THR_W'($urandom),
                   16'd1, THR_W'($urandom), 16'd58982};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset threshold: extremes, touching edges, empty boxes, the 0.7 boundary.
        send_rect(1'b0, -32768, -32768, 32767, 32767);
        send_rect(1'b0, -32768, -32768, 32767, 32767);
        send_rect(1'b0, -1, -32768, 10, 10);
        send_rect(1'b0, 32767, 32767, 32767, 32767);
        send_rect(1'b1, 0, 0, 0, 0);
        send_rect(1'b0, 0, 0, 0, 0);
        send_rect(1'b0, 0, 0, 100, 100);
        send_rect(1'b0, 0, 0, 100, 70);
        send_rect(1'b0, 0, 0, 100, 69);
        send_rect(1'b0, 50, 50, 0, 40);
        send_rect(1'b0, 100, 0, 100, 100);

        // A zero threshold drops any real overlap but not a touch.
        write_threshold('0);
        send_rect(1'b1, 10, 10, 20, 20);
        send_rect(1'b0, 30, 10, 20, 20);
        send_rect(1'b0, 29, 29, 2, 2);
        send_rect(1'b0, -5, -5, 0, 0);
        send_rect(1'b0, -5, -5, 0, 0);

        // The largest threshold still drops an identical box.
        write_threshold('1);
        send_rect(1'b1, 1000, -1000, 300, 300);
        send_rect(1'b0, 1000, -1000, 300, 300);
        send_rect(1'b0, 1001, -1000, 300, 300);

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            write_threshold(limits[p]);
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS)
                run_frame(p == PHASE_COUNT - 1);
        end

        drain();
        repeat (MAX_KEPT + 16) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
